[src/bthm_pkg.sv]
`default_nettype none

package bthm_pkg;

   localparam int TS_W      = 64;
   localparam int LEN_W     = 16;
   localparam int BYTES_W   = 32;
   localparam int NPB_W     = 8;
   localparam int PROD_W    = LEN_W + NPB_W;
   localparam logic [NPB_W-1:0] NPB_RESET = 8'd8;

   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_DUMP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SCAN,
      ST_MERGE,
      ST_SHIFT,
      ST_DUMP_RD,
      ST_DUMP_LD,
      ST_DUMP_WAIT
   } bthm_state_type;

   function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                   input logic [BYTES_W-1:0] b);
      logic [BYTES_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
   endfunction

endpackage

`default_nettype wire

[src/bounded_time_histogram_merge.sv]
// Bounded time histogram with smallest-adjacent-pair merging.
//
// Input channel req_*: tuser carries func (add or dump), tdata carries the
// packet timestamp and length. One item is taken at a time; req_tready is
// high only while the sequencer is idle.
// Result channel rsp_*: one item per bucket on a dump, in time order, with
// rsp_tlast on the final bucket. An add gives no result.
// csr_wen/csr_wdata write ns_per_byte. The user must write it only while the
// block is idle; the block itself has no guard against writes at other times.
//
// An add that does not overflow is accepted, then written. An overflowing
// add scans the BUCKETS+1 byte totals through one read port and one
// adder/comparator, writes the merged bucket and then moves the later
// buckets down one entry a cycle. A dump reads each bucket through the
// single registered read port, loads it into the output register and waits
// for the receiver. A dump with no buckets gives no result and stays idle.
// Reset empties the list and sets ns_per_byte to 8. When the receiver stalls
// the current bucket is held in the output register until it is taken.
`default_nettype none

module bounded_time_histogram_merge
   import bthm_pkg::*;
#(
   parameter int BUCKETS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [79:0]   req_tdata,   // timestamp[63:0], length[79:64]
   input  wire logic          req_tuser,   // func
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic      [95:0]   rsp_tdata,   // bucket_end_time[63:0], bucket_bytes[95:64]
   output logic               rsp_tlast,
   input  wire logic          csr_wen,
   input  wire logic [7:0]    csr_wdata
);

   localparam int DEPTH  = BUCKETS + 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(BUCKETS + 2);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BUCKETS + 1);
   localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);
   localparam logic [CNT_W-1:0] TWO        = CNT_W'(2);

   bthm_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic [TS_W-1:0]      base_ff, base_in;
   logic [NPB_W-1:0]     npb_ff;
   logic                 out_valid_ff, out_valid_in;

   logic [TS_W-1:0]      ts_ff, ts_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [ADDR_W-1:0]    best_ff, best_in;
   logic [BYTES_W:0]     best_sum_ff, best_sum_in;
   logic [BYTES_W-1:0]   best_lo_ff, best_lo_in;
   logic [BYTES_W-1:0]   best_hi_ff, best_hi_in;
   logic [TS_W-1:0]      best_end_ff, best_end_in;
   logic [BYTES_W-1:0]   prev_ff, prev_in;
   logic [TS_W-1:0]      out_end_ff, out_end_in;
   logic [BYTES_W-1:0]   out_bytes_ff, out_bytes_in;
   logic                 out_last_ff, out_last_in;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [TS_W-1:0]      wr_end;
   logic [BYTES_W-1:0]   wr_bytes;
   logic [ADDR_W-1:0]    rd_addr;
   logic [TS_W-1:0]      rd_end;
   logic [BYTES_W-1:0]   rd_bytes;

   logic                 req_fire;
   logic [PROD_W-1:0]    prod;
   logic [BYTES_W:0]     pair_sum;
   logic [CNT_W-1:0]     best_ext;

   assign req_fire = req_tvalid && req_tready;
   assign prod     = PROD_W'(len_ff) * PROD_W'(npb_ff);
   assign pair_sum = {1'b0, prev_ff} + {1'b0, rd_bytes};
   assign best_ext = CNT_W'(best_ff);

   bthm_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_end   (wr_end),
      .wr_bytes (wr_bytes),
      .rd_addr  (rd_addr),
      .rd_end   (rd_end),
      .rd_bytes (rd_bytes)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      out_valid_in = out_valid_ff;
      ts_in        = ts_ff;
      len_in       = len_ff;
      best_in      = best_ff;
      best_sum_in  = best_sum_ff;
      best_lo_in   = best_lo_ff;
      best_hi_in   = best_hi_ff;
      best_end_in  = best_end_ff;
      prev_in      = prev_ff;
      out_end_in   = out_end_ff;
      out_bytes_in = out_bytes_ff;
      out_last_in  = out_last_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_end       = '0;
      wr_bytes     = '0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ts_in  = req_tdata[63:0];
               len_in = req_tdata[79:64];
               idx_in = '0;
               if (req_tuser == FUNC_DUMP) begin
                  if (count_ff != '0) begin
                     state_in = ST_DUMP_RD;
                  end
               end else if (req_tdata[79:64] != '0) begin
                  state_in = ST_ADD;
               end
            end
         end

         ST_ADD: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[ADDR_W-1:0];
            wr_bytes = BYTES_W'(len_ff);
            if (count_ff == '0) begin
               // first packet: ts minus base is the back-dated span itself
               base_in = ts_ff - TS_W'(prod);
               wr_end  = TS_W'(prod);
            end else begin
               wr_end  = ts_ff - base_ff;
            end
            count_in = count_ff + ONE;
            idx_in   = '0;
            if (count_ff + ONE == FULL_COUNT) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // read entry idx while the data of entry idx-1 arrives
            if (idx_ff < count_ff) begin
               rd_addr = idx_ff[ADDR_W-1:0];
            end
            if (idx_ff >= ONE) begin
               prev_in = rd_bytes;
            end
            if (idx_ff >= TWO) begin
               // strict compare keeps the earliest pair on a tie
               if (idx_ff == TWO || pair_sum < best_sum_ff) begin
                  best_sum_in = pair_sum;
                  best_in     = ADDR_W'(idx_ff - TWO);
                  best_lo_in  = prev_ff;
                  best_hi_in  = rd_bytes;
                  best_end_in = rd_end;
               end
            end
            if (idx_ff == count_ff) begin
               state_in = ST_MERGE;
            end else begin
               idx_in = idx_ff + ONE;
            end
         end

         ST_MERGE: begin
            wr_en    = 1'b1;
            wr_addr  = best_ff;
            wr_end   = best_end_ff;
            wr_bytes = sat_add(best_lo_ff, best_hi_ff);
            idx_in   = best_ext + ONE;
            if (best_ext + TWO < count_ff) begin
               rd_addr  = ADDR_W'(best_ext + TWO);
               state_in = ST_SHIFT;
            end else begin
               count_in = count_ff - ONE;
               state_in = ST_IDLE;
            end
         end

         ST_SHIFT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff[ADDR_W-1:0];
            wr_end   = rd_end;
            wr_bytes = rd_bytes;
            if (idx_ff + TWO < count_ff) begin
               rd_addr = ADDR_W'(idx_ff + TWO);
               idx_in  = idx_ff + ONE;
            end else begin
               count_in = count_ff - ONE;
               state_in = ST_IDLE;
            end
         end

         ST_DUMP_RD: begin
            rd_addr  = idx_ff[ADDR_W-1:0];
            state_in = ST_DUMP_LD;
         end

         ST_DUMP_LD: begin
            out_end_in   = rd_end;
            out_bytes_in = rd_bytes;
            out_last_in  = (idx_ff + ONE == count_ff);
            out_valid_in = 1'b1;
            state_in     = ST_DUMP_WAIT;
         end

         ST_DUMP_WAIT: begin
            if (rsp_tready) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ONE;
                  state_in = ST_DUMP_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         base_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         base_ff      <= base_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         npb_ff <= NPB_RESET;
      end else if (csr_wen) begin
         npb_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff        <= ts_in;
      len_ff       <= len_in;
      best_ff      <= best_in;
      best_sum_ff  <= best_sum_in;
      best_lo_ff   <= best_lo_in;
      best_hi_ff   <= best_hi_in;
      best_end_ff  <= best_end_in;
      prev_ff      <= prev_in;
      out_end_ff   <= out_end_in;
      out_bytes_ff <= out_bytes_in;
      out_last_ff  <= out_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_bytes_ff, out_end_ff};
   assign rsp_tlast  = out_last_ff;

   // the list never rests above its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (count_ff <= CNT_W'(BUCKETS)))
      else $error("bucket count above capacity while idle");

   // a merge only follows a full scan of an overflowing list
   a_merge_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (count_ff == FULL_COUNT && $past(state_ff) == ST_SCAN))
      else $error("merge without overflow");

   // a result is only presented while the dump waits on the receiver
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (state_ff == ST_DUMP_WAIT))
      else $error("result valid outside dump");

   // the chosen pair always lies inside the list
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (best_ext + ONE < count_ff))
      else $error("merge pair out of range");

endmodule

`default_nettype wire

[src/bthm_store.sv]
`default_nettype none

module bthm_store
   import bthm_pkg::*;
#(
   parameter int DEPTH  = 33,
   parameter int ADDR_W = 6
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire logic [TS_W-1:0]     wr_end,
   input  wire logic [BYTES_W-1:0]  wr_bytes,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output logic      [TS_W-1:0]     rd_end,
   output logic      [BYTES_W-1:0]  rd_bytes
);

   logic [TS_W-1:0]    end_mem   [0:DEPTH-1];
   logic [BYTES_W-1:0] bytes_mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         end_mem[wr_addr]   <= wr_end;
         bytes_mem[wr_addr] <= wr_bytes;
      end
   end

   // registered read, one address a cycle
   always_ff @(posedge clock) begin
      rd_end   <= end_mem[rd_addr];
      rd_bytes <= bytes_mem[rd_addr];
   end

endmodule

`default_nettype wire
